// ----- rtl/core/gsme_pkg.sv -----
// Package for the gas-sensor perceptron estimator: fixed-point formats, layer
// sizes and the constant Q6.12 weight and bias tables.
// No dependencies; used by gsme_layer and gas_sensor_mlp_estimator_unit.
package gsme_pkg;

  localparam int LayerWidth   = 4;
  localparam int NetworkDepth = 5;
  localparam int NumLayers    = NetworkDepth - 1;

  // Field and datapath widths.
  localparam int InW     = 16;  // input field, 6 fractional bits
  localparam int OutW    = 24;  // result field, 8 fractional bits
  localparam int ActW    = 31;  // activation magnitude, 12 fractional bits, never negative
  localparam int WeightW = 18;  // Q6.12 signed
  localparam int ProdW   = 50;  // signed activation times weight, 24 fractional bits
  localparam int SumW    = 53;  // four products plus bias, with headroom
  localparam int FracW   = 12;

  typedef logic [ActW-1:0]                 act_t;
  typedef act_t [LayerWidth-1:0]           act_vec_t;
  typedef logic signed [WeightW-1:0]       weight_t;
  typedef logic signed [ProdW-1:0]         prod_t;
  typedef logic signed [SumW-1:0]          sum_t;
  typedef logic [OutW-1:0]                 out_t;

  localparam act_t ActMax = {ActW{1'b1}};
  localparam out_t OutMax = {OutW{1'b1}};

  // Nodes per layer; lanes beyond the size of a layer carry zero.
  localparam int LayerSize [NetworkDepth] = '{4, 4, 4, 4, 1};

  // Weight[layer][source node][destination node], Q6.12.
  localparam weight_t Weight [NumLayers][LayerWidth][LayerWidth] = '{
    '{ '{-18'sd1821,  -18'sd964,    18'sd69,   -18'sd132},
       '{-18'sd2816, -18'sd1942,   18'sd963,   -18'sd132},
       '{   18'sd88,   18'sd344,  18'sd2029,   -18'sd132},
       '{ 18'sd4444,  18'sd2885, -18'sd3140,   -18'sd132} },
    '{ '{  18'sd927,  18'sd1646,  -18'sd226,   -18'sd752},
       '{ 18'sd6203,  18'sd1923,   18'sd245,   18'sd3814},
       '{ 18'sd3315, -18'sd2499, -18'sd12295,  18'sd3993},
       '{   -18'sd2,     18'sd2,     18'sd0,      18'sd2} },
    '{ '{-18'sd8663, -18'sd5302,     18'sd0, -18'sd6735},
       '{ 18'sd2632,  18'sd5762,     18'sd0,  18'sd5153},
       '{  18'sd331,   18'sd250,     18'sd0, -18'sd7346},
       '{ 18'sd6366,  18'sd8210,     18'sd0,  18'sd7817} },
    '{ '{18'sd37741, 18'sd37741, 18'sd37741, 18'sd37741},
       '{18'sd13337, 18'sd13337, 18'sd13337, 18'sd13337},
       '{    18'sd0,     18'sd0,     18'sd0,     18'sd0},
       '{18'sd14022, 18'sd14022, 18'sd14022, 18'sd14022} }
  };

  // Bias[layer][destination node], Q6.12.
  localparam weight_t Bias [NumLayers][LayerWidth] = '{
    '{ 18'sd10586,  18'sd12026,  18'sd77229,  18'sd1855},
    '{-18'sd60267,  -18'sd3534, -18'sd22211, 18'sd67313},
    '{ 18'sd21607,  18'sd60201,  -18'sd2989, 18'sd60440},
    '{ 18'sd56955,      18'sd0,      18'sd0,     18'sd0}
  };

endpackage

// ----- rtl/core/gsme_layer.sv -----
// One perceptron layer as a three-stage pipeline: multiply, sum with bias,
// then ReLU with rounding and saturation. Depends on gsme_pkg.
module gsme_layer #(
  parameter int unsigned LAYER_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  gsme_pkg::act_vec_t act_i,
  output logic              valid_o,
  input  logic              ready_i,
  output gsme_pkg::act_vec_t act_o
);

  localparam int RndW = gsme_pkg::SumW - gsme_pkg::FracW;

  gsme_pkg::prod_t  prod_d [gsme_pkg::LayerWidth][gsme_pkg::LayerWidth];
  gsme_pkg::prod_t  prod_q [gsme_pkg::LayerWidth][gsme_pkg::LayerWidth];
  gsme_pkg::sum_t   sum_d  [gsme_pkg::LayerWidth];
  gsme_pkg::sum_t   sum_q  [gsme_pkg::LayerWidth];
  gsme_pkg::act_vec_t act_d, act_q;

  logic mul_vld_q, sum_vld_q, act_vld_q;
  logic mul_en, sum_en, act_en;

  // Each stage moves when it is empty or the stage after it moves.
  assign act_en  = !act_vld_q || ready_i;
  assign sum_en  = !sum_vld_q || act_en;
  assign mul_en  = !mul_vld_q || sum_en;
  assign ready_o = mul_en;

  // Stage 1: one product per source and destination node.
  always_comb begin
    for (int s = 0; s < gsme_pkg::LayerWidth; s++) begin
      for (int d = 0; d < gsme_pkg::LayerWidth; d++) begin
        prod_d[s][d] = gsme_pkg::ProdW'($signed({1'b0, act_i[s]}))
                     * gsme_pkg::ProdW'(gsme_pkg::Weight[LAYER_IDX][s][d]);
      end
    end
  end

  // Stage 2: accumulate the products on top of the bias scaled to 24 fractional bits.
  always_comb begin
    for (int d = 0; d < gsme_pkg::LayerWidth; d++) begin
      sum_d[d] = gsme_pkg::SumW'(gsme_pkg::Bias[LAYER_IDX][d]) <<< gsme_pkg::FracW;
      for (int s = 0; s < gsme_pkg::LayerWidth; s++) begin
        sum_d[d] = sum_d[d] + gsme_pkg::SumW'(prod_q[s][d]);
      end
    end
  end

  // Stage 3: ReLU, round half up back to 12 fractional bits, saturate.
  always_comb begin
    gsme_pkg::sum_t  rnd_full;
    logic [RndW-1:0] rnd;
    for (int d = 0; d < gsme_pkg::LayerWidth; d++) begin
      rnd_full = sum_q[d] + gsme_pkg::SumW'(2048);
      rnd      = rnd_full[gsme_pkg::SumW-1:gsme_pkg::FracW];
      if (d >= gsme_pkg::LayerSize[LAYER_IDX+1] || sum_q[d] <= 0) begin
        act_d[d] = '0;
      end else if (rnd > RndW'(gsme_pkg::ActMax)) begin
        act_d[d] = gsme_pkg::ActMax;
      end else begin
        act_d[d] = rnd[gsme_pkg::ActW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
      act_vld_q <= 1'b0;
    end else begin
      if (mul_en) mul_vld_q <= valid_i;
      if (sum_en) sum_vld_q <= mul_vld_q;
      if (act_en) act_vld_q <= sum_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en && valid_i) prod_q <= prod_d;
    if (sum_en && mul_vld_q) sum_q <= sum_d;
    if (act_en && sum_vld_q) act_q <= act_d;
  end

  assign valid_o = act_vld_q;
  assign act_o   = act_q;

endmodule

// ----- rtl/core/gas_sensor_mlp_estimator_unit.sv -----
// Top level of the gas-sensor perceptron estimator: stream ports, four
// pipelined layers and the output conversion stage.
// Depends on gsme_pkg and gsme_layer.
//
//   Port group   Direction  Payload
//   s_axis_*     in         four 16-bit ADC averages, 6 fractional bits
//   m_axis_*     out        24-bit estimate, 8 fractional bits, saturated
//
// An item may be accepted in every cycle while the output is not stalled. Each
// layer takes three register stages (multiply, sum, activate) and one output
// register follows. An item passes through these thirteen stages in order,
// and the output register presents its result.
// Reset clears only the valid bits; the data registers are not reset.
// Every stage has its own valid bit and advances when empty or when the next
// stage advances, so bubbles close up and a stall loses or repeats nothing.
module gas_sensor_mlp_estimator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] avg_one_minute, [31:16] avg_ten_minutes,
  // [47:32] avg_one_hour, [63:48] avg_one_day
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [23:0] estimate_value
  output logic [23:0] m_axis_tdata
);

  localparam int NumLayers = gsme_pkg::NumLayers;
  localparam int InW       = gsme_pkg::InW;
  localparam int ActW      = gsme_pkg::ActW;
  localparam int ShW       = ActW + 1 - 4;

  // Activation vectors and handshakes between the layers; index 0 is the input.
  gsme_pkg::act_vec_t act_chain [NumLayers+1];
  logic               vld_chain [NumLayers+1];
  logic               rdy_chain [NumLayers+1];

  logic               out_vld_q;
  gsme_pkg::out_t     out_q, out_d;
  logic               out_en;

  // Inputs move from 6 to 12 fractional bits on their way into the first layer.
  always_comb begin
    for (int i = 0; i < gsme_pkg::LayerWidth; i++) begin
      act_chain[0][i] = {{(ActW-InW-6){1'b0}}, s_axis_tdata[i*InW +: InW], 6'b0};
    end
  end

  assign vld_chain[0]  = s_axis_tvalid;
  assign s_axis_tready = rdy_chain[0];

  for (genvar l = 0; l < NumLayers; l++) begin : g_layer
    gsme_layer #(
      .LAYER_IDX(l)
    ) u_layer (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld_chain[l]),
      .ready_o(rdy_chain[l]),
      .act_i  (act_chain[l]),
      .valid_o(vld_chain[l+1]),
      .ready_i(rdy_chain[l+1]),
      .act_o  (act_chain[l+1])
    );
  end

  // The output register takes the single last-layer node and converts it from
  // 12 to 8 fractional bits with round half up, saturating at the field maximum.
  assign out_en                = !out_vld_q || m_axis_tready;
  assign rdy_chain[NumLayers]  = out_en;

  always_comb begin
    logic [ActW:0]  rnd_full;
    logic [ShW-1:0] rnd;
    rnd_full = {1'b0, act_chain[NumLayers][0]} + (ActW+1)'(8);
    rnd      = rnd_full[ActW:4];
    if (rnd > ShW'(gsme_pkg::OutMax)) begin
      out_d = gsme_pkg::OutMax;
    end else begin
      out_d = rnd[gsme_pkg::OutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_en) begin
      out_vld_q <= vld_chain[NumLayers];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && vld_chain[NumLayers]) out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
